// File: rtl/core/lru2_heap_block_cache_tags_assert.svh
// Assertion macros for the block cache tag engine checks.
`ifndef LRU2_HEAP_BLOCK_CACHE_TAGS_ASSERT_SVH
`define LRU2_HEAP_BLOCK_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRU2HC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru2hc check failed");

// Next-cycle implication.
`define LRU2HC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru2hc check failed");

`endif

// File: rtl/core/lru2hc_pkg.sv
// ----------------------------------------------------------------------------
// lru2hc_pkg
// Shared types and codes of the LRU-2 block cache tag engine.
// ----------------------------------------------------------------------------
package lru2hc_pkg;

  localparam int DEF_ENTRIES = 256;

  // request codes
  localparam logic [1:0] MODE_GET   = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_REL   = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_FULL  = 3'd1;
  localparam logic [2:0] STAT_ZERO  = 3'd2;
  localparam logic [2:0] STAT_LOCAL = 3'd3;
  localparam logic [2:0] STAT_BAD   = 3'd4;
  localparam logic [2:0] STAT_OVF   = 3'd5;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SCAN, S_CLAIM, S_CLAIM_RD, S_POP, S_POP_E, S_POP_F,
    S_RM_L, S_RM_K, S_RM_END, S_FILL, S_REL_RD, S_REL,
    S_UP, S_UP_Q, S_UP_C, S_DN, S_DN_A, S_DN_B, S_DN_C, S_DN_CMP, S_DONE
  } st_t;

  // what follows a heap sift
  typedef enum logic [1:0] {CTX_HIT, CTX_REL, CTX_POP} ctx_t;

endpackage

// File: rtl/core/lru2_heap_block_cache_tags.sv
// ----------------------------------------------------------------------------
// lru2_heap_block_cache_tags
// Tag lookup and LRU-2 victim heap for a block cache, one sequencer driving
// entry, tag and heap memories with one read and one write port each.
// ----------------------------------------------------------------------------
// Sequence: a get scans one tag row per cycle, then a hit sift or a miss
//   claim; each heap level is read and written on the heap and entry
//   memory ports, each pop one remove with its sift. Release: an entry
//   read, then a sift-up. Alloc: a claim plus pops. Then the result loads out.
// Throughput: one beat in flight; in_stall stays high from accept to result.
// Reset: a clearing pass sweeps every entry of the per-entry state memories.
module lru2_heap_block_cache_tags import lru2hc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_score_a,
  input  logic [63:0] in_score_b,
  input  logic [31:0] in_score_c,
  input  logic [7:0]  in_kind,
  input  logic [7:0]  in_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_slot,
  output logic        out_hit,
  output logic [2:0]  out_status
);

  localparam int IW = $clog2(ENTRIES);        // entry index
  localparam int PW = $clog2(ENTRIES + 1);    // heap position / counts
  localparam int KW = PW + 1;                 // child index
  localparam int SW = $clog2(ENTRIES + 2);    // scan counter
  localparam logic [PW-1:0] ABSENT = PW'(ENTRIES);

  // --------------------------------------------------------------------------
  // Memories: tags, per-entry state, heap. One read, one write port each,
  // registered read data.
  // --------------------------------------------------------------------------
  logic [63:0]   thi_mem   [ENTRIES];
  logic [63:0]   tmid_mem  [ENTRIES];
  logic [31:0]   tlo_mem   [ENTRIES];
  logic [7:0]    tkind_mem [ENTRIES];
  logic          valid_mem [ENTRIES];
  logic [7:0]    ref_mem   [ENTRIES];
  logic [31:0]   last_mem  [ENTRIES];
  logic [31:0]   prior_mem [ENTRIES];
  logic [PW-1:0] hpos_mem  [ENTRIES];
  logic [IW-1:0] heap_mem  [ENTRIES];

  logic [IW-1:0] ent_ra, ent_wa, heap_ra, heap_wa, heap_wd;
  logic          tag_we, we_valid, we_ref, we_last, we_prior, we_hpos, heap_we;
  logic [63:0]   thi_wd, tmid_wd, thi_rd, tmid_rd;
  logic [31:0]   tlo_wd, tlo_rd, last_wd, last_rd, prior_wd, prior_rd;
  logic [7:0]    tkind_wd, tkind_rd, ref_wd, ref_rd;
  logic          valid_wd, valid_rd;
  logic [PW-1:0] hpos_wd, hpos_rd;
  logic [IW-1:0] heap_rd;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      thi_mem[ent_wa]   <= thi_wd;
      tmid_mem[ent_wa]  <= tmid_wd;
      tlo_mem[ent_wa]   <= tlo_wd;
      tkind_mem[ent_wa] <= tkind_wd;
    end
    if (we_valid) valid_mem[ent_wa] <= valid_wd;
    if (we_ref)   ref_mem[ent_wa]   <= ref_wd;
    if (we_last)  last_mem[ent_wa]  <= last_wd;
    if (we_prior) prior_mem[ent_wa] <= prior_wd;
    if (we_hpos)  hpos_mem[ent_wa]  <= hpos_wd;
    if (heap_we)  heap_mem[heap_wa] <= heap_wd;
    thi_rd   <= thi_mem[ent_ra];
    tmid_rd  <= tmid_mem[ent_ra];
    tlo_rd   <= tlo_mem[ent_ra];
    tkind_rd <= tkind_mem[ent_ra];
    valid_rd <= valid_mem[ent_ra];
    ref_rd   <= ref_mem[ent_ra];
    last_rd  <= last_mem[ent_ra];
    prior_rd <= prior_mem[ent_ra];
    hpos_rd  <= hpos_mem[ent_ra];
    heap_rd  <= heap_mem[heap_ra];
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  st_t            st_r, st_nxt, after_st;
  ctx_t           ctx_r, ctx_nxt;
  logic           reheap_r, reheap_nxt;
  logic [SW-1:0]  scan_r, scan_nxt;
  logic           chk_r, chk_nxt;
  logic [IW-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]  v_r, v_nxt, e_r, e_nxt, q_r, q_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [PW-1:0]  i_r, i_nxt, i0_r, i0_nxt, p_r, p_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [31:0]    keye_r, keye_nxt, keya_r, keya_nxt, keyq_r, keyq_nxt;
  logic [31:0]    pv_r, pv_nxt, uclk_r, uclk_nxt;
  logic [7:0]     refv_r, refv_nxt;
  logic [PW-1:0]  hcnt_r, hcnt_nxt, ucnt_r, ucnt_nxt;
  logic [7:0]     res_slot_r, res_slot_nxt;
  logic           res_hit_r, res_hit_nxt;
  logic [2:0]     res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt, load_out;
  logic [7:0]     out_slot_r;
  logic           out_hit_r;
  logic [2:0]     out_status_r;

  // latched request
  logic [1:0]  mode_r;
  logic [63:0] sa_r, sb_r;
  logic [31:0] sc_r;
  logic [7:0]  kind_r, ent_r;
  logic        in_acc;

  assign in_stall   = (st_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      scan_r      <= '0;
      hcnt_r      <= '0;
      ucnt_r      <= PW'(ENTRIES);
      uclk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      scan_r      <= scan_nxt;
      hcnt_r      <= hcnt_nxt;
      ucnt_r      <= ucnt_nxt;
      uclk_r      <= uclk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r        <= ctx_nxt;
    reheap_r     <= reheap_nxt;
    chk_r        <= chk_nxt;
    chk_idx_r    <= chk_idx_nxt;
    v_r          <= v_nxt;
    e_r          <= e_nxt;
    q_r          <= q_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    i_r          <= i_nxt;
    i0_r         <= i0_nxt;
    p_r          <= p_nxt;
    k_r          <= k_nxt;
    keye_r       <= keye_nxt;
    keya_r       <= keya_nxt;
    keyq_r       <= keyq_nxt;
    pv_r         <= pv_nxt;
    refv_r       <= refv_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      mode_r <= in_mode;
      sa_r   <= in_score_a;
      sb_r   <= in_score_b;
      sc_r   <= in_score_c;
      kind_r <= in_kind;
      ent_r  <= in_entry;
    end
    if (load_out) begin
      out_slot_r   <= res_slot_r;
      out_hit_r    <= res_hit_r;
      out_status_r <= res_status_r;
    end
  end

  // where a finished sift hands back to
  always_comb begin
    unique case (ctx_r)
      CTX_POP: after_st = S_RM_END;
      default: after_st = S_DONE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    logic [31:0] keyb;
    logic        match;
    keyb  = prior_rd - uclk_r;
    match = chk_r && valid_rd && thi_rd == sa_r && tmid_rd == sb_r &&
            tlo_rd == sc_r && tkind_rd == kind_r;

    st_nxt = st_r;  ctx_nxt = ctx_r;  reheap_nxt = reheap_r;
    scan_nxt = scan_r;  chk_nxt = chk_r;  chk_idx_nxt = chk_idx_r;
    v_nxt = v_r;  e_nxt = e_r;  q_nxt = q_r;  a_nxt = a_r;  b_nxt = b_r;
    i_nxt = i_r;  i0_nxt = i0_r;  p_nxt = p_r;  k_nxt = k_r;
    keye_nxt = keye_r;  keya_nxt = keya_r;  keyq_nxt = keyq_r;
    pv_nxt = pv_r;  refv_nxt = refv_r;
    hcnt_nxt = hcnt_r;  ucnt_nxt = ucnt_r;  uclk_nxt = uclk_r;
    res_slot_nxt = res_slot_r;  res_hit_nxt = res_hit_r;
    res_status_nxt = res_status_r;
    load_out = 1'b0;

    ent_ra = '0;  ent_wa = '0;  heap_ra = '0;  heap_wa = '0;  heap_wd = '0;
    tag_we = 1'b0;  we_valid = 1'b0;  we_ref = 1'b0;  we_last = 1'b0;
    we_prior = 1'b0;  we_hpos = 1'b0;  heap_we = 1'b0;
    thi_wd = '0;  tmid_wd = '0;  tlo_wd = '0;  tkind_wd = kind_r;
    valid_wd = 1'b0;  ref_wd = '0;  last_wd = '0;  prior_wd = '0;
    hpos_wd = ABSENT;

    unique case (st_r)
      S_CLR: begin
        ent_wa   = scan_r[IW-1:0];
        we_valid = 1'b1;  we_ref = 1'b1;  we_last = 1'b1;
        we_prior = 1'b1;  we_hpos = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SW'(ENTRIES - 1)) st_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_acc) begin
          res_slot_nxt   = '0;
          res_hit_nxt    = 1'b0;
          res_status_nxt = STAT_OK;
          priority case (in_mode)
            MODE_GET: begin
              scan_nxt = '0;
              chk_nxt  = 1'b0;
              st_nxt   = S_SCAN;
            end
            MODE_ALLOC: st_nxt = S_CLAIM;
            MODE_REL: begin
              res_slot_nxt = in_entry;
              if (32'(in_entry) >= 32'(ENTRIES)) begin
                res_status_nxt = STAT_BAD;
                st_nxt = S_DONE;
              end else begin
                st_nxt = S_REL_RD;
              end
            end
            default: begin
              res_status_nxt = STAT_BAD;
              st_nxt = S_DONE;
            end
          endcase
        end
      end

      // one tag row per cycle, compare on the registered read
      S_SCAN: begin
        ent_ra      = (scan_r < SW'(ENTRIES)) ? scan_r[IW-1:0] : '0;
        chk_nxt     = (scan_r < SW'(ENTRIES));
        chk_idx_nxt = scan_r[IW-1:0];
        scan_nxt    = scan_r + 1'b1;
        if (match) begin
          res_slot_nxt = 8'(chk_idx_r);
          res_hit_nxt  = 1'b1;
          e_nxt        = chk_idx_r;
          if (ref_rd == 8'hFF) begin
            res_status_nxt = STAT_OVF;
            st_nxt = S_DONE;
          end else begin
            ent_wa   = chk_idx_r;
            we_ref   = 1'b1;  ref_wd   = ref_rd + 8'd1;
            we_prior = 1'b1;  prior_wd = last_rd;
            we_last  = 1'b1;  last_wd  = uclk_r;
            uclk_nxt = uclk_r + 32'd1;
            keye_nxt = last_rd - (uclk_r + 32'd1);
            if (hpos_rd < ABSENT) begin
              i_nxt = hpos_rd;  i0_nxt = hpos_rd;
              reheap_nxt = 1'b1;  ctx_nxt = CTX_HIT;
              st_nxt = S_UP;
            end else begin
              st_nxt = S_DONE;
            end
          end
        end else if (!chk_r && scan_r >= SW'(ENTRIES)) begin
          if (sa_r == '0 && sb_r == '0) begin
            res_status_nxt = (sc_r == '0) ? STAT_ZERO : STAT_LOCAL;
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_CLAIM;
          end
        end
      end

      S_CLAIM: begin
        if (ucnt_r != '0) begin
          ucnt_nxt = ucnt_r - 1'b1;
          v_nxt    = IW'(ucnt_r - 1'b1);
          ent_ra   = IW'(ucnt_r - 1'b1);
          st_nxt   = S_CLAIM_RD;
        end else begin
          st_nxt = S_POP;
        end
      end

      S_CLAIM_RD: begin
        pv_nxt = prior_rd;
        st_nxt = S_FILL;
      end

      S_POP: begin
        if (hcnt_r == '0) begin
          res_status_nxt = STAT_FULL;
          res_slot_nxt   = '0;
          res_hit_nxt    = 1'b0;
          st_nxt = S_DONE;
        end else begin
          heap_ra = '0;
          st_nxt  = S_POP_E;
        end
      end

      S_POP_E: begin
        v_nxt  = heap_rd;
        ent_ra = heap_rd;
        st_nxt = S_POP_F;
      end

      S_POP_F: begin
        refv_nxt = ref_rd;
        pv_nxt   = prior_rd;
        if (hpos_rd >= ABSENT) begin
          st_nxt = S_RM_END;
        end else begin
          hcnt_nxt = hcnt_r - 1'b1;
          i_nxt    = hpos_rd;
          i0_nxt   = hpos_rd;
          heap_ra  = IW'(hcnt_r - 1'b1);
          st_nxt   = S_RM_L;
        end
      end

      // last heap element fills the hole
      S_RM_L: begin
        e_nxt  = heap_rd;
        ent_ra = heap_rd;
        st_nxt = S_RM_K;
      end

      S_RM_K: begin
        keye_nxt   = prior_rd - uclk_r;
        reheap_nxt = 1'b1;
        ctx_nxt    = CTX_POP;
        st_nxt     = S_UP;
      end

      S_RM_END: begin
        ent_wa  = v_r;
        we_hpos = 1'b1;
        hpos_wd = ABSENT;
        st_nxt  = (refv_r == '0) ? S_FILL : S_POP;
      end

      // tag the claimed entry; midpoint stamp then one use
      S_FILL: begin
        ent_wa   = v_r;
        tag_we   = 1'b1;
        thi_wd   = (mode_r == MODE_GET) ? sa_r : '0;
        tmid_wd  = (mode_r == MODE_GET) ? sb_r : '0;
        tlo_wd   = (mode_r == MODE_GET) ? sc_r : 32'(v_r) + 32'd1;
        we_valid = 1'b1;  valid_wd = 1'b1;
        we_ref   = 1'b1;  ref_wd   = 8'd1;
        we_prior = 1'b1;  prior_wd = (pv_r + uclk_r) >> 1;
        we_last  = 1'b1;  last_wd  = uclk_r;
        uclk_nxt = uclk_r + 32'd1;
        res_slot_nxt   = 8'(v_r);
        res_status_nxt = STAT_OK;
        st_nxt = S_DONE;
      end

      S_REL_RD: begin
        ent_ra = IW'(ent_r);
        st_nxt = S_REL;
      end

      S_REL: begin
        if (ref_rd == '0) begin
          res_status_nxt = STAT_BAD;
          st_nxt = S_DONE;
        end else begin
          ent_wa = IW'(ent_r);
          we_ref = 1'b1;
          ref_wd = ref_rd - 8'd1;
          if (ref_rd == 8'd1 && hpos_rd >= ABSENT && hcnt_r < ABSENT) begin
            hcnt_nxt   = hcnt_r + 1'b1;
            i_nxt      = hcnt_r;
            i0_nxt     = hcnt_r;
            e_nxt      = IW'(ent_r);
            keye_nxt   = prior_rd - uclk_r;
            reheap_nxt = 1'b0;
            ctx_nxt    = CTX_REL;
            st_nxt     = S_UP;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end

      // sift-up: stop on equal keys
      S_UP: begin
        if (i_r == '0) begin
          heap_we = 1'b1;  heap_wa = i_r[IW-1:0];  heap_wd = e_r;
          we_hpos = 1'b1;  ent_wa  = e_r;          hpos_wd = i_r;
          st_nxt  = (reheap_r && i_r == i0_r) ? S_DN : after_st;
        end else begin
          p_nxt   = (i_r - 1'b1) >> 1;
          heap_ra = IW'((i_r - 1'b1) >> 1);
          st_nxt  = S_UP_Q;
        end
      end

      S_UP_Q: begin
        q_nxt  = heap_rd;
        ent_ra = heap_rd;
        st_nxt = S_UP_C;
      end

      S_UP_C: begin
        heap_we = 1'b1;
        heap_wa = i_r[IW-1:0];
        we_hpos = 1'b1;
        hpos_wd = i_r;
        if (keye_r >= keyb) begin
          heap_wd = e_r;
          ent_wa  = e_r;
          st_nxt  = (reheap_r && i_r == i0_r) ? S_DN : after_st;
        end else begin
          heap_wd = q_r;
          ent_wa  = q_r;
          i_nxt   = p_r;
          st_nxt  = S_UP;
        end
      end

      // sift-down: left child wins ties
      S_DN: begin
        k_nxt = {i_r, 1'b1};
        if ({i_r, 1'b1} >= {1'b0, hcnt_r}) begin
          heap_we = 1'b1;  heap_wa = i_r[IW-1:0];  heap_wd = e_r;
          we_hpos = 1'b1;  ent_wa  = e_r;          hpos_wd = i_r;
          st_nxt  = after_st;
        end else begin
          heap_ra = IW'({i_r, 1'b1});
          st_nxt  = S_DN_A;
        end
      end

      S_DN_A: begin
        a_nxt   = heap_rd;
        ent_ra  = heap_rd;
        heap_ra = (k_r + 1'b1 < {1'b0, hcnt_r}) ? IW'(k_r + 1'b1) : '0;
        st_nxt  = S_DN_B;
      end

      S_DN_B: begin
        keya_nxt = keyb;
        if (k_r + 1'b1 < {1'b0, hcnt_r}) begin
          b_nxt  = heap_rd;
          ent_ra = heap_rd;
          st_nxt = S_DN_C;
        end else begin
          q_nxt    = a_r;
          keyq_nxt = keyb;
          st_nxt   = S_DN_CMP;
        end
      end

      S_DN_C: begin
        if (keya_r > keyb) begin
          q_nxt    = b_r;
          keyq_nxt = keyb;
          k_nxt    = k_r + 1'b1;
        end else begin
          q_nxt    = a_r;
          keyq_nxt = keya_r;
        end
        st_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        heap_we = 1'b1;
        heap_wa = i_r[IW-1:0];
        we_hpos = 1'b1;
        hpos_wd = i_r;
        if (keye_r <= keyq_r) begin
          heap_wd = e_r;
          ent_wa  = e_r;
          st_nxt  = after_st;
        end else begin
          heap_wd = q_r;
          ent_wa  = q_r;
          i_nxt   = PW'(k_r);
          st_nxt  = S_DN;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          st_nxt   = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

endmodule

// File: rtl/core/lru2hc_chk.sv
// ----------------------------------------------------------------------------
// lru2hc_chk
// Port-level checks of the block cache tag engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru2_heap_block_cache_tags_assert.svh"

module lru2hc_chk import lru2hc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_slot,
  input logic       out_hit,
  input logic [2:0] out_status
);

  // a held result beat stays up
  `LRU2HC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // one request in flight: busy right after a beat is taken
  `LRU2HC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a hit only ends ok or in count overflow
  `LRU2HC_ASSERT_IMP(a_hit_status, out_valid && out_hit,
                     out_status == STAT_OK || out_status == STAT_OVF)

  // refused lookups and a full cache report slot zero, no hit
  `LRU2HC_ASSERT_IMP(a_refuse_slot,
                     out_valid && (out_status == STAT_FULL || out_status == STAT_ZERO ||
                                   out_status == STAT_LOCAL),
                     out_slot == 8'd0 && !out_hit)

endmodule

bind lru2_heap_block_cache_tags lru2hc_chk u_lru2hc_chk (.*);
